### sv/psd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the point-to-segment distance core.
// No dependencies; imported by every module of the block.
package psd_pkg;

  // Widths of the internal datapath
  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = CoordW + 1;       // P-A and B-A
  localparam int unsigned LenW   = 2 * DiffW;        // |B-A|^2 and dot product
  localparam int unsigned TW     = 17;               // t in Q1.16, 65536 = 1.0
  localparam int unsigned QW     = TW - 1;           // quotient bits of the divider
  localparam int unsigned RootW  = 36;               // floor sqrt result bits
  localparam int unsigned RadW   = 2 * RootW;        // radicand bits
  localparam int unsigned RemW   = RootW + 4;        // sqrt partial remainder
  localparam int unsigned DistW  = 33;

  // Fraction bits of the coordinates and the degenerate-segment threshold
  localparam int unsigned      FracBits = 16;
  localparam logic [LenW-1:0] EpsRaw   = LenW'((64'd1 << (2 * FracBits)) / 64'd10000);
  localparam logic [TW-1:0]   TOne     = TW'(1) << QW;

  // How t is chosen for an item
  typedef enum logic [1:0] {
    TSEL_ZERO,
    TSEL_ONE,
    TSEL_DIV
  } tsel_e;

  // Word carried through the divider stages
  typedef struct packed {
    logic [LenW-1:0]        rem;
    logic [LenW-1:0]        len;
    logic [QW-1:0]          q;
    tsel_e                  mode;
    logic signed [DiffW-1:0] vx;
    logic signed [DiffW-1:0] vy;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
  } div_t;

  // Word carried through the square-root stages
  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [TW-1:0]    t;
  } sqr_t;

endpackage

### sv/psd_front.sv
`timescale 1ns / 1ps
// Front end: differences, products, squared length and dot product, t mode.
// Depends on psd_pkg. Four register stages, all advanced by en_i.
module psd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [191:0]         data_i,    // point_x, point_y, start_x, start_y, end_x, end_y
  output logic                 valid_o,
  output psd_pkg::div_t        data_o
);
  import psd_pkg::*;

  logic [CoordW-1:0] px, py, ax, ay, bx, by;
  logic signed [DiffW-1:0] dx_d, dy_d, vx_d, vy_d;
  logic signed [DiffW-1:0] dx1_q, dy1_q, vx1_q, vy1_q;
  logic signed [DiffW-1:0] dx2_q, dy2_q, vx2_q, vy2_q;
  logic signed [DiffW-1:0] dx3_q, dy3_q, vx3_q, vy3_q;
  logic signed [LenW-1:0]  pdd_q, pyy_q, pvx_q, pvy_q;
  logic [LenW-1:0]         len_q;
  logic signed [LenW-1:0]  dot_q;
  logic [3:0]              vld_q;
  div_t                    out_d, out_q;

  assign px = data_i[31:0];
  assign py = data_i[63:32];
  assign ax = data_i[95:64];
  assign ay = data_i[127:96];
  assign bx = data_i[159:128];
  assign by = data_i[191:160];

  // Differences, sign extended by one bit
  assign dx_d = $signed({bx[CoordW-1], bx}) - $signed({ax[CoordW-1], ax});
  assign dy_d = $signed({by[CoordW-1], by}) - $signed({ay[CoordW-1], ay});
  assign vx_d = $signed({px[CoordW-1], px}) - $signed({ax[CoordW-1], ax});
  assign vy_d = $signed({py[CoordW-1], py}) - $signed({ay[CoordW-1], ay});

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q <= dx_d;
      dy1_q <= dy_d;
      vx1_q <= vx_d;
      vy1_q <= vy_d;
      // products
      pdd_q <= dx1_q * dx1_q;
      pyy_q <= dy1_q * dy1_q;
      pvx_q <= vx1_q * dx1_q;
      pvy_q <= vy1_q * dy1_q;
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
      vx2_q <= vx1_q;
      vy2_q <= vy1_q;
      // sums
      len_q <= $unsigned(pdd_q + pyy_q);
      dot_q <= pvx_q + pvy_q;
      dx3_q <= dx2_q;
      dy3_q <= dy2_q;
      vx3_q <= vx2_q;
      vy3_q <= vy2_q;
      out_q <= out_d;
    end
  end

  // Pick t mode: degenerate or behind A gives 0, past B gives 1.0
  always_comb begin
    out_d     = '0;
    out_d.rem = $unsigned(dot_q);
    out_d.len = len_q;
    out_d.vx  = vx3_q;
    out_d.vy  = vy3_q;
    out_d.dx  = dx3_q;
    out_d.dy  = dy3_q;
    if (len_q <= EpsRaw) begin
      out_d.mode = TSEL_ZERO;
    end else if (dot_q[LenW-1] || (dot_q == '0)) begin
      out_d.mode = TSEL_ZERO;
    end else if ($unsigned(dot_q) >= len_q) begin
      out_d.mode = TSEL_ONE;
    end else begin
      out_d.mode = TSEL_DIV;
    end
  end

  assign valid_o = vld_q[3];
  assign data_o  = out_q;

endmodule

### sv/psd_div_stage.sv
`timescale 1ns / 1ps
// One restoring-division stage: one quotient bit of dot / |B-A|^2 per stage.
// Depends on psd_pkg.
module psd_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  psd_pkg::div_t data_i,
  output logic          valid_o,
  output psd_pkg::div_t data_o
);
  import psd_pkg::*;

  logic [LenW-1:0] sh;
  div_t            data_d, data_q;
  logic            valid_q;

  // Shift, trial subtract, record quotient bit
  always_comb begin
    sh     = {data_i.rem[LenW-2:0], 1'b0};
    data_d = data_i;
    if (sh >= data_i.len) begin
      data_d.rem = sh - data_i.len;
      data_d.q   = {data_i.q[QW-2:0], 1'b1};
    end else begin
      data_d.rem = sh;
      data_d.q   = {data_i.q[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/psd_err.sv
`timescale 1ns / 1ps
// Error vector e = 65536*(P-A) - t*(B-A) and its squared length >> 32.
// Depends on psd_pkg. Five register stages, all advanced by en_i.
module psd_err (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  psd_pkg::div_t data_i,
  output logic          valid_o,
  output psd_pkg::sqr_t data_o
);
  import psd_pkg::*;

  localparam int unsigned PW = DiffW + TW + 1;   // dx * t
  localparam int unsigned EW = PW + 1;           // e, signed
  localparam int unsigned MW = EW - 1;           // |e|
  localparam int unsigned LoW = MW / 2;
  localparam int unsigned HiW = MW - LoW;
  localparam int unsigned SqW = 2 * MW;

  logic [TW-1:0]           t_d, t1_q, t2_q, t3_q, t4_q;
  logic signed [PW-1:0]    pxt_q, pyt_q;
  logic signed [DiffW-1:0] vx1_q, vy1_q;
  logic signed [EW-1:0]    ex, ey;
  logic [MW-1:0]           mx_q, my_q;
  logic [2*HiW-1:0]        hhx_q, hhy_q;
  logic [HiW+LoW-1:0]      hlx_q, hly_q;
  logic [2*LoW-1:0]        llx_q, lly_q;
  logic [SqW-1:0]          sqx_q, sqy_q;
  logic [SqW:0]            ssum;
  logic [4:0]              vld_q;
  sqr_t                    out_q;

  // Final t from the mode and the quotient
  always_comb begin
    case (data_i.mode)
      TSEL_ONE: t_d = TOne;
      TSEL_DIV: t_d = {1'b0, data_i.q};
      default:  t_d = '0;
    endcase
  end

  // e = (v << 16) - d*t
  assign ex = (EW'(vx1_q) <<< QW) - EW'(pxt_q);
  assign ey = (EW'(vy1_q) <<< QW) - EW'(pyt_q);
  assign ssum = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // scale d by t
      pxt_q <= data_i.dx * $signed({1'b0, t_d});
      pyt_q <= data_i.dy * $signed({1'b0, t_d});
      vx1_q <= data_i.vx;
      vy1_q <= data_i.vy;
      t1_q  <= t_d;
      // magnitudes
      mx_q  <= ex[EW-1] ? MW'(-ex) : MW'(ex);
      my_q  <= ey[EW-1] ? MW'(-ey) : MW'(ey);
      t2_q  <= t1_q;
      // partial products of the squares
      hhx_q <= mx_q[MW-1 -: HiW] * mx_q[MW-1 -: HiW];
      hlx_q <= mx_q[MW-1 -: HiW] * mx_q[LoW-1:0];
      llx_q <= mx_q[LoW-1:0] * mx_q[LoW-1:0];
      hhy_q <= my_q[MW-1 -: HiW] * my_q[MW-1 -: HiW];
      hly_q <= my_q[MW-1 -: HiW] * my_q[LoW-1:0];
      lly_q <= my_q[LoW-1:0] * my_q[LoW-1:0];
      t3_q  <= t2_q;
      // assemble each square
      sqx_q <= (SqW'(hhx_q) << (2 * LoW)) + (SqW'(hlx_q) << (LoW + 1)) + SqW'(llx_q);
      sqy_q <= (SqW'(hhy_q) << (2 * LoW)) + (SqW'(hly_q) << (LoW + 1)) + SqW'(lly_q);
      t4_q  <= t3_q;
      // drop the 32 fraction bits of t^2 scaling
      out_q.rad  <= RadW'(ssum[SqW:2*QW]);
      out_q.rem  <= '0;
      out_q.root <= '0;
      out_q.t    <= t4_q;
    end
  end

  assign valid_o = vld_q[4];
  assign data_o  = out_q;

endmodule

### sv/psd_sqrt_stage.sv
`timescale 1ns / 1ps
// One digit-by-digit square-root stage: one root bit per stage.
// Depends on psd_pkg.
module psd_sqrt_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  psd_pkg::sqr_t data_i,
  output logic          valid_o,
  output psd_pkg::sqr_t data_o
);
  import psd_pkg::*;

  logic [RemW-1:0] r2, trial;
  sqr_t            data_d, data_q;
  logic            valid_q;

  // Bring down two radicand bits, try root*4+1
  always_comb begin
    r2         = {data_i.rem[RemW-3:0], data_i.rad[RadW-1 -: 2]};
    trial      = {2'b00, data_i.root, 2'b01};
    data_d     = data_i;
    data_d.rad = {data_i.rad[RadW-3:0], 2'b00};
    if (r2 >= trial) begin
      data_d.rem  = r2 - trial;
      data_d.root = {data_i.root[RootW-2:0], 1'b1};
    end else begin
      data_d.rem  = r2;
      data_d.root = {data_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/point_segment_distance_core.sv
`timescale 1ns / 1ps
// Point-to-segment distance core: top level, chains front end, divider,
// error stage and square root. Depends on psd_pkg and all psd_* modules.
//
// Takes one word per cycle while not stalled and returns one word per item
// (4 front-end stages, 16 divider stages, 5 error stages, 36 root stages).
// Throughput is one item per clock; the whole pipeline holds while the
// output word waits and m_axis_tready is low. No state is kept between
// items and no setup is needed after reset.
module point_segment_distance_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // point_x, point_y, start_x, start_y, end_x, end_y
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata    // position_t[16:0], distance[49:17], zero pad
);
  import psd_pkg::*;

  logic         en;
  logic [QW:0]  div_vld;
  div_t         div_dat [QW+1];
  logic [RootW:0] sq_vld;
  sqr_t         sq_dat [RootW+1];

  // Global advance: move when the output slot is empty or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  psd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .valid_o (div_vld[0]),
    .data_o  (div_dat[0])
  );

  // Divider chain
  for (genvar i = 0; i < QW; i++) begin : g_div
    psd_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_vld[i]),
      .data_i  (div_dat[i]),
      .valid_o (div_vld[i+1]),
      .data_o  (div_dat[i+1])
    );
  end

  psd_err u_err (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld[QW]),
    .data_i  (div_dat[QW]),
    .valid_o (sq_vld[0]),
    .data_o  (sq_dat[0])
  );

  // Square-root chain; the last stage is the output register
  for (genvar j = 0; j < RootW; j++) begin : g_sqrt
    psd_sqrt_stage u_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_vld[j]),
      .data_i  (sq_dat[j]),
      .valid_o (sq_vld[j+1]),
      .data_o  (sq_dat[j+1])
    );
  end

  assign m_axis_tvalid = sq_vld[RootW];
  assign m_axis_tdata  = {6'b0, sq_dat[RootW].root[DistW-1:0], sq_dat[RootW].t};

`ifndef NO_ASSERTIONS
  // t never exceeds 1.0
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[16:0] <= TOne))
    else $error("position_t above 1.0");

  // a stall freezes the divider and square-root valid bits
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(div_vld) && $stable(sq_vld)))
    else $error("pipeline moved during stall");

  // divider remainder stays below the divisor on live division words
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_vld[QW] && (div_dat[QW].mode == TSEL_DIV)) |-> (div_dat[QW].rem < div_dat[QW].len))
    else $error("divider remainder out of range");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for point_segment_distance_core: streams point/segment queries
// and checks every result word against an in-bench distance predictor or typed-in values.
// Depends on psd_pkg and the core RTL.
module tb;
  import psd_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned FlushCycles   = 100;
  localparam int unsigned HoldCycles    = 300;

  typedef struct packed {
    logic [TW-1:0]    pos_t;
    logic [DistW-1:0] dist_val;
  } dist_res_t;

  // One directed query; has_exp marks rows whose result is typed in
  typedef struct {
    logic signed [31:0] px, py, ax, ay, bx, by;
    bit                 has_exp;
    logic [TW-1:0]      pos_t;
    logic [DistW-1:0]   dist_val;
  } query_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;   // point_x, point_y, start_x, start_y, end_x, end_y
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [55:0]  m_axis_tdata;   // position_t[16:0], distance[49:17], zero pad

  dist_res_t   pending_dist_q[$];
  dist_res_t   typed_q[$];      // typed-in expectations, matched with has_typed_q
  bit          has_typed_q[$];
  bit          typed_flag_next;
  dist_res_t   typed_next;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned quiet_cycles;
  bit          failed;
  bit          hold_go;         // asks the receiver for its long hold-off

  point_segment_distance_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Distance predictor: clamped projection t, then floor of the exact distance
  function automatic dist_res_t seg_distance(input logic [191:0] w);
    logic signed [127:0] px, py, ax, ay, bx, by, dx, dy, vx, vy;
    logic signed [127:0] len_sq, dot, ex, ey, sq, sr, cand;
    logic [127:0]        t;
    logic [127:0]        root;
    dist_res_t           r;
    px = $signed(w[31:0]);    py = $signed(w[63:32]);
    ax = $signed(w[95:64]);   ay = $signed(w[127:96]);
    bx = $signed(w[159:128]); by = $signed(w[191:160]);
    dx = bx - ax; dy = by - ay;
    vx = px - ax; vy = py - ay;
    len_sq = dx * dx + dy * dy;
    t = 0;
    // degenerate segment collapses to point A
    if (len_sq > $signed({1'b0, EpsRaw})) begin
      dot = vx * dx + vy * dy;
      if (dot <= 0) t = 0;
      else if (dot >= len_sq) t = 65536;
      else t = (dot <<< 16) / len_sq;
    end
    ex = (vx <<< 16) - dx * $signed(t);
    ey = (vy <<< 16) - dy * $signed(t);
    sq = ex * ex + ey * ey;
    sr = sq >>> 32;
    root = 0;
    for (int b = 35; b >= 0; b--) begin
      cand = $signed(root | (128'd1 << b));
      if (cand * cand <= sr) root = cand;
    end
    r.pos_t    = t[TW-1:0];
    r.dist_val = root[DistW-1:0];
    return r;
  endfunction

  function automatic logic signed [31:0] q16(input int v);
    return 32'(v) <<< 16;
  endfunction

  function automatic query_row_t mk_row(input logic signed [31:0] px, py, ax, ay, bx, by,
                                        input bit has_exp, input int pt, input longint d);
    query_row_t r;
    r.px = px; r.py = py; r.ax = ax; r.ay = ay; r.bx = bx; r.by = by;
    r.has_exp = has_exp; r.pos_t = TW'(pt); r.dist_val = DistW'(d);
    return r;
  endfunction

  // Random coordinate: mostly moderate, sometimes full range or extreme
  function automatic logic [31:0] rand_coord();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 55) return 32'($signed($urandom_range(2097151)) - 1048576);
    else if (k < 85) return $urandom;
    else if (k < 90) return 32'h7fff_ffff;
    else if (k < 95) return 32'h8000_0000;
    else return 32'($urandom_range(3)) - 32'd1;
  endfunction

  // Result checker and idle watchdog
  always @(posedge clk_i) begin
    dist_res_t got;
    dist_res_t exp_r;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: timeout, no word moved", $time);
        $display("Some tests failed");
        $finish;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_dist_q = {pending_dist_q, seg_distance(s_axis_tdata)};
        has_typed_q    = {has_typed_q, typed_flag_next};
        typed_q        = {typed_q, typed_next};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.pos_t    = m_axis_tdata[16:0];
        got.dist_val = m_axis_tdata[49:17];
        if (pending_dist_q.size() == 0) begin
          $display("%0t: result word with nothing expected, actual t=%0d dist=%0d",
                   $time, got.pos_t, got.dist_val);
          failed = 1'b1;
        end else begin
          exp_r = pending_dist_q.pop_front();
          // typed-in rows override the predictor
          if (has_typed_q.pop_front()) exp_r = typed_q.pop_front();
          else void'(typed_q.pop_front());
          if (got.pos_t !== exp_r.pos_t) begin
            $display("%0t: position_t mismatch, expected %0d actual %0d",
                     $time, exp_r.pos_t, got.pos_t);
            failed = 1'b1;
          end
          if (got.dist_val !== exp_r.dist_val) begin
            $display("%0t: distance mismatch, expected %0d actual %0d",
                     $time, exp_r.dist_val, got.dist_val);
            failed = 1'b1;
          end
        end
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Receiver: random stalls, plus one long hold-off once the random traffic
  // starts, so the pipe fills and the input stalls
  initial begin
    bit held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_query(input logic [191:0] w, input bit has_exp, input dist_res_t e);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= w;
    typed_flag_next <= has_exp;
    typed_next      <= e;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stimulus
  initial begin
    query_row_t  rows[$];
    logic [191:0] w;
    dist_res_t   e;
    logic [31:0] ax, ay, bx, by;
    int unsigned kind;

    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    typed_flag_next = 1'b0;
    typed_next      = '0;
    snd_idle_pct    = 35;
    rcv_idle_pct    = 71;
    failed          = 1'b0;
    hold_go         = 1'b0;
    rst_ni          = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: basic geometry, clamping, degenerate segments, extremes
    rows = {rows, mk_row(0, 0, 0, 0, 0, 0, 1, 0, 0)};
    rows = {rows, mk_row(q16(1), q16(1), 0, 0, q16(2), 0, 1, 32768, 65536)};
    rows = {rows, mk_row(q16(3), q16(4), q16(7), q16(7), q16(7), q16(7), 1, 0, 327680)};
    rows = {rows, mk_row(q16(3), q16(4), 0, 0, 0, 0, 1, 0, 327680)};
    rows = {rows, mk_row(-q16(1), 0, 0, 0, q16(1), 0, 1, 0, 65536)};
    rows = {rows, mk_row(q16(3), 0, 0, 0, q16(1), 0, 1, 65536, 131072)};
    rows = {rows, mk_row(q16(1), 0, 0, 0, q16(1), 0, 1, 65536, 0)};
    rows = {rows, mk_row(0, q16(5), 0, 0, q16(4), 0, 1, 0, 327680)};
    rows = {rows, mk_row(q16(5), q16(5), 0, 0, 655, 0, 0, 0, 0)};
    rows = {rows, mk_row(q16(5), q16(5), 0, 0, 656, 0, 0, 0, 0)};
    rows = {rows, mk_row(q16(5), 3, 0, 0, 0, 656, 0, 0, 0)};
    rows = {rows, mk_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         32'h7fffffff, 32'h7fffffff, 1, 0, 0)};
    rows = {rows, mk_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                         32'h80000000, 32'h80000000, 1, 0, 0)};
    rows = {rows, mk_row(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                         32'h7fffffff, 32'h7fffffff, 0, 0, 0)};
    rows = {rows, mk_row(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                         32'h7fffffff, 32'h80000000, 0, 0, 0)};
    rows = {rows, mk_row(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                         32'h7fffffff, 32'h80000000, 0, 0, 0)};
    rows = {rows, mk_row(0, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 0, 0, 0, 0)};
    rows = {rows, mk_row(-1, -1, 0, 0, 1, 1, 0, 0, 0)};
    rows = {rows, mk_row(32'hffffffff, 32'h0000ffff, 32'h12345678, 32'hedcba987,
                         32'h80000001, 32'h7ffffffe, 0, 0, 0)};
    foreach (rows[i]) begin
      e.pos_t    = rows[i].pos_t;
      e.dist_val = rows[i].dist_val;
      send_query({rows[i].by, rows[i].bx, rows[i].ay, rows[i].ax, rows[i].py, rows[i].px},
                 rows[i].has_exp, e);
    end

    // sender pause until everything has drained
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_dist_q.size() != 0);

    // receiver holds off while the random traffic starts
    hold_go = 1'b1;

    // random queries in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 71 : 0;
      rcv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 35 : 0;
      for (int n = 0; n < 134; n++) begin
        ax = rand_coord(); ay = rand_coord();
        kind = $urandom_range(9);
        if (kind < 6) begin
          bx = rand_coord(); by = rand_coord();
        end else if (kind < 8) begin
          // short segment around the degenerate threshold
          bx = ax + 32'($signed($urandom_range(1400)) - 700);
          by = ay + 32'($signed($urandom_range(20)) - 10);
        end else begin
          bx = ax; by = ay;
        end
        w = {by, bx, ay, ax, rand_coord(), rand_coord()};
        send_query(w, 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain and flush
    do @(posedge clk_i); while (pending_dist_q.size() != 0);
    repeat (FlushCycles) @(posedge clk_i);
    if (!failed && pending_dist_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/psd_pkg.sv
sv/psd_front.sv
sv/psd_div_stage.sv
sv/psd_err.sv
sv/psd_sqrt_stage.sv
sv/point_segment_distance_core.sv
tb/tb.sv
